### rtl/hctc_pkg.sv
// Package for the histogram class transition counter.
// Holds sizes, command codes and the word type passed from front to back.
package hctc_pkg;

  localparam int DIRS       = 8;
  localparam int TABLE_ROWS = 64;
  localparam int CLASSES    = 16;
  localparam int COUNT_BITS = 32;
  localparam int ROW_BITS   = 6;
  localparam int CLS_BITS   = 4;
  localparam int CELLS      = CLASSES * CLASSES;
  localparam int CELL_BITS  = 8;
  localparam int QDEPTH     = 2;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_DIGIT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic KIND_TRANS = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Classified work for the back end.
  // mute: first vector with a bad digit, raises the error flag only.
  typedef struct packed {
    logic                is_read;
    logic                mute;
    logic                ok;
    logic                bad;
    logic [CLS_BITS-1:0] from_cls;
    logic [CLS_BITS-1:0] to_cls;
  } job_t;

endpackage

### rtl/hctc_front.sv
// Front end: table load, histogram build and table search per vector.
// Depends on hctc_pkg; pushes job_t words into the queue.
module hctc_front
  import hctc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [6:0]  table_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_direction,
  input  logic        in_last_digit,
  input  logic [5:0]  in_entry_index,
  input  logic [31:0] in_entry_key,
  input  logic [3:0]  in_entry_class,
  input  logic [3:0]  in_read_row,
  input  logic [3:0]  in_read_col,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_full
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]          keys_mem [TABLE_ROWS];
  logic [CLS_BITS-1:0]  cls_mem  [TABLE_ROWS];
  logic [31:0]          key_rd_r;
  logic [CLS_BITS-1:0]  cls_rd_r;

  logic [3:0]  hist_r [DIRS];
  logic        bad_r;
  logic        have_prev_r;
  logic [31:0] prev_key_r;
  logic [31:0] cur_key_r;
  logic [31:0] srch_prev_r;
  logic [6:0]  row_r;
  logic        rd_vld_r;
  logic [6:0]  limit;
  logic        f_found_r, t_found_r;
  logic [CLS_BITS-1:0] f_cls_r, t_cls_r;
  job_t        job_r;
  logic        accept;
  logic [31:0] packed_key;
  logic [3:0]  dsel;
  logic        dok;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign limit = (table_size > 7'(TABLE_ROWS)) ? 7'(TABLE_ROWS) : table_size;
  assign dok = (in_direction >= 4'd1) && (in_direction <= 4'(DIRS));
  assign dsel = in_direction - 4'd1;
  assign job_valid = (state_r == S_PUSH);
  assign job = job_r;

  always_comb begin
    packed_key = '0;
    for (int d = 0; d < DIRS; d++) begin
      packed_key[4*d +: 4] = hist_r[d];
    end
    if (dok && hist_r[dsel[2:0]] != 4'hf) begin
      packed_key[4*dsel[2:0] +: 4] = hist_r[dsel[2:0]] + 4'd1;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && in_command == CMD_LOAD) begin
      keys_mem[in_entry_index] <= in_entry_key;
      cls_mem[in_entry_index]  <= in_entry_class;
    end
    key_rd_r <= keys_mem[row_r[ROW_BITS-1:0]];
    cls_rd_r <= cls_mem[row_r[ROW_BITS-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_command == CMD_READ) state_nxt = S_PUSH;
        else if (accept && in_command == CMD_DIGIT && in_last_digit) begin
          if (have_prev_r) state_nxt = S_SRCH;
          else if (bad_r || !dok) state_nxt = S_PUSH;
        end
      end
      S_SRCH: if (row_r == limit && !rd_vld_r) state_nxt = S_PUSH;
      S_PUSH: if (!job_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bad_r       <= 1'b0;
      have_prev_r <= 1'b0;
      prev_key_r  <= '0;
      rd_vld_r    <= 1'b0;
      row_r       <= '0;
      for (int d = 0; d < DIRS; d++) hist_r[d] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && accept && in_command == CMD_DIGIT) begin
        if (in_last_digit) begin
          for (int d = 0; d < DIRS; d++) hist_r[d] <= '0;
          bad_r       <= 1'b0;
          prev_key_r  <= packed_key;
          cur_key_r   <= packed_key;
          have_prev_r <= 1'b1;
          job_r.is_read  <= 1'b0;
          job_r.mute     <= !have_prev_r;
          job_r.ok       <= 1'b0;
          job_r.bad      <= bad_r || !dok;
          job_r.from_cls <= '0;
          job_r.to_cls   <= '0;
          row_r     <= '0;
          rd_vld_r  <= 1'b0;
          f_found_r <= 1'b0;
          t_found_r <= 1'b0;
          f_cls_r   <= '0;
          t_cls_r   <= '0;
        end else begin
          if (dok && hist_r[dsel[2:0]] != 4'hf)
            hist_r[dsel[2:0]] <= hist_r[dsel[2:0]] + 4'd1;
          if (!dok) bad_r <= 1'b1;
        end
      end
      if (state_r == S_IDLE && accept && in_command == CMD_READ) begin
        job_r.is_read  <= 1'b1;
        job_r.mute     <= 1'b0;
        job_r.ok       <= 1'b0;
        job_r.bad      <= 1'b0;
        job_r.from_cls <= in_read_row;
        job_r.to_cls   <= in_read_col;
      end
      if (state_r == S_SRCH) begin
        // Issue row reads, compare the row read last cycle.
        rd_vld_r <= (row_r != limit);
        if (row_r != limit) row_r <= row_r + 7'd1;
        if (rd_vld_r) begin
          if (!f_found_r && key_rd_r == srch_prev_r) begin
            f_found_r <= 1'b1;
            f_cls_r   <= cls_rd_r;
          end
          if (!t_found_r && key_rd_r == cur_key_r) begin
            t_found_r <= 1'b1;
            t_cls_r   <= cls_rd_r;
          end
        end
        if (row_r == limit && !rd_vld_r) begin
          job_r.ok       <= f_found_r && t_found_r;
          job_r.from_cls <= f_found_r ? f_cls_r : '0;
          job_r.to_cls   <= t_found_r ? t_cls_r : '0;
        end
      end
    end
  end

  // Key of the earlier vector, captured when a search starts.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept && in_command == CMD_DIGIT && in_last_digit)
      srch_prev_r <= prev_key_r;
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> in_stall) else $error("front accepts while pushing");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (row_r <= limit)) else $error("row past limit");
  a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_full) |=> (job_valid && $stable(job)))
    else $error("queued word changed while held");
`endif

endmodule

### rtl/hctc_back.sv
// Back end: queue, counter memory with clear sweep, error flag, output register.
// Depends on hctc_pkg; takes job_t words from hctc_front.
module hctc_back
  import hctc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_full,
  output logic        busy_clear,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [3:0]  out_from_class,
  output logic [3:0]  out_to_class,
  output logic [31:0] out_cell_count,
  output logic        out_counted,
  output logic        out_error_seen
);

  typedef enum logic [3:0] {
    B_CLR  = 4'b0001,
    B_IDLE = 4'b0010,
    B_RD   = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;

  job_t       q_r [QDEPTH];
  logic [1:0] q_cnt_r;
  logic       q_wp_r, q_rp_r;
  logic       push, pop;

  logic [COUNT_BITS-1:0] cnt_mem [CELLS];
  logic [COUNT_BITS-1:0] rd_r;
  logic [CELL_BITS-1:0]  clr_r;
  logic                  we;
  logic [CELL_BITS-1:0]  waddr;
  logic [COUNT_BITS-1:0] wdata;
  job_t                  cur_r;
  logic                  err_r;
  logic [COUNT_BITS-1:0] inc;

  assign job_full = (q_cnt_r == 2'(QDEPTH));
  assign push = job_valid && !job_full;
  assign pop  = (state_r == B_IDLE) && (q_cnt_r != 2'd0);
  assign busy_clear = (state_r == B_CLR);
  assign inc = (rd_r == '1) ? rd_r : rd_r + 1'b1;

  always_comb begin
    we = 1'b0;
    waddr = {cur_r.from_cls, cur_r.to_cls};
    wdata = inc;
    if (state_r == B_CLR) begin
      we = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else if (state_r == B_RD && !cur_r.is_read && cur_r.ok) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) cnt_mem[waddr] <= wdata;
    rd_r <= cnt_mem[{q_r[q_rp_r].from_cls, q_r[q_rp_r].to_cls}];
    if (push) q_r[q_wp_r] <= job;
    if (pop) cur_r <= q_r[q_rp_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLR:  if (clr_r == CELL_BITS'(CELLS - 1)) state_nxt = B_IDLE;
      B_IDLE: if (pop) state_nxt = B_RD;
      B_RD:   state_nxt = cur_r.mute ? B_IDLE : B_OUT;
      B_OUT:  if (!out_stall) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_CLR;
      clr_r     <= '0;
      q_cnt_r   <= '0;
      q_wp_r    <= 1'b0;
      q_rp_r    <= 1'b0;
      err_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLR) clr_r <= clr_r + 1'b1;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
      if (push) q_wp_r <= !q_wp_r;
      if (pop)  q_rp_r <= !q_rp_r;
      if (state_r == B_RD) begin
        out_valid       <= !cur_r.mute;
        out_result_kind <= cur_r.is_read ? KIND_READ : KIND_TRANS;
        out_from_class  <= cur_r.from_cls;
        out_to_class    <= cur_r.to_cls;
        out_counted     <= !cur_r.is_read && cur_r.ok;
        out_cell_count  <= cur_r.is_read ? rd_r : (cur_r.ok ? inc : '0);
        out_error_seen  <= err_r ||
                           (!cur_r.is_read && (cur_r.bad || !cur_r.ok));
        if (!cur_r.is_read && (cur_r.bad || !cur_r.ok)) err_r <= 1'b1;
      end else if (state_r == B_OUT && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'(QDEPTH)) else $error("queue overflow");
  a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
    busy_clear |-> !out_valid) else $error("result during clear");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r) else $error("error flag dropped");
`endif

endmodule

### rtl/histogram_class_transition_counter.sv
// Top level of the histogram class transition counter.
// Depends on hctc_pkg, hctc_front and hctc_back.
//
// After reset the counter store is cleared, all 256 cells, one cell a
// cycle, and no item is taken then. Loads and plain digits cause no stall;
// a closing digit after an earlier vector stalls the input while the
// table search reads one row a cycle from the table memory (up to
// table_size rows, at most 64). Reads pass the front's push state.
module histogram_class_transition_counter
  import hctc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_table_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_direction,
  input  logic        in_last_digit,
  input  logic [5:0]  in_entry_index,
  input  logic [31:0] in_entry_key,
  input  logic [3:0]  in_entry_class,
  input  logic [3:0]  in_read_row,
  input  logic [3:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [3:0]  out_from_class,
  output logic [3:0]  out_to_class,
  output logic [31:0] out_cell_count,
  output logic        out_counted,
  output logic        out_error_seen
);

  logic [6:0] table_size_r;
  logic       job_valid, job_full, busy_clear, front_stall;
  job_t       job;

  assign cfg_ready = 1'b1;
  assign in_stall = front_stall || busy_clear;

  always_ff @(posedge clk) begin
    if (!rst_n) table_size_r <= '0;
    else if (cfg_valid && cfg_ready) table_size_r <= cfg_table_size;
  end

  hctc_front u_front (
    .clk, .rst_n,
    .table_size (table_size_r),
    .in_valid   (in_valid && !busy_clear),
    .in_stall   (front_stall),
    .in_command, .in_direction, .in_last_digit, .in_entry_index,
    .in_entry_key, .in_entry_class, .in_read_row, .in_read_col,
    .job_valid, .job, .job_full
  );

  hctc_back u_back (
    .clk, .rst_n, .job_valid, .job, .job_full,
    .busy_clear,
    .out_valid, .out_stall, .out_result_kind, .out_from_class,
    .out_to_class, .out_cell_count, .out_counted, .out_error_seen
  );

endmodule

### bench/histogram_class_transition_counter_tb.sv
// Testbench for histogram_class_transition_counter: drives loads, digits and reads,
// predicts each result word from its own copy of table, histogram and count matrix.
// Depends on hctc_pkg and the RTL of the block.
module histogram_class_transition_counter_tb;
  import hctc_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  dir;
    logic        last;
    logic [5:0]  idx;
    logic [31:0] key;
    logic [3:0]  cls;
    logic [3:0]  rrow;
    logic [3:0]  rcol;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  from_c;
    logic [3:0]  to_c;
    logic [31:0] cnt;
    logic        counted;
    logic        err;
  } res_t;

  localparam logic [1:0] CMD_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_table_size = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [3:0]  in_direction = '0;
  logic        in_last_digit = 1'b0;
  logic [5:0]  in_entry_index = '0;
  logic [31:0] in_entry_key = '0;
  logic [3:0]  in_entry_class = '0;
  logic [3:0]  in_read_row = '0;
  logic [3:0]  in_read_col = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [3:0]  out_from_class;
  logic [3:0]  out_to_class;
  logic [31:0] out_cell_count;
  logic        out_counted;
  logic        out_error_seen;

  histogram_class_transition_counter dut (.*);

  always #5 clk = ~clk;

  // predictor state
  bit [31:0] tbl_key [TABLE_ROWS];
  bit [3:0]  tbl_cls [TABLE_ROWS];
  bit [31:0] cell_cnt [CELLS];
  bit [3:0]  hist [DIRS];
  bit [31:0] prev_key;
  bit        have_prev, err_sticky, bad_vec;
  int        size_now;

  item_t pend_q[$];
  res_t  expect_q[$];
  bit [31:0] gen_key [TABLE_ROWS];
  int  n_items, n_pushed, n_taken, fails;
  bit  no_gaps;
  int  hold_req;

  function automatic bit lookup(bit [31:0] key, output bit [3:0] c);
    int n;
    n = size_now < TABLE_ROWS ? size_now : TABLE_ROWS;
    c = '0;
    for (int r = 0; r < n; r++)
      if (tbl_key[r] == key) begin
        c = tbl_cls[r];
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic void predict_item(item_t it);
    res_t r;
    bit [31:0] k;
    bit [3:0] fc, tc;
    bit okf, okt;
    r = '0;
    k = '0;
    case (it.cmd)
      CMD_LOAD: begin
        tbl_key[it.idx] = it.key;
        tbl_cls[it.idx] = it.cls;
      end
      CMD_DIGIT: begin
        if (it.dir >= 1 && it.dir <= DIRS) begin
          if (hist[it.dir-1] != 4'hF) hist[it.dir-1]++;
        end else bad_vec = 1'b1;
        if (it.last) begin
          for (int d = 0; d < DIRS; d++) k[4*d +: 4] = hist[d];
          if (bad_vec) err_sticky = 1'b1;
          if (have_prev) begin
            okf = lookup(prev_key, fc);
            okt = lookup(k, tc);
            r.kind = KIND_TRANS;
            r.from_c = fc;
            r.to_c = tc;
            if (okf && okt) begin
              if (cell_cnt[{fc, tc}] != '1) cell_cnt[{fc, tc}]++;
              r.cnt = cell_cnt[{fc, tc}];
              r.counted = 1'b1;
            end else err_sticky = 1'b1;
            r.err = err_sticky;
            expect_q.push_back(r);
          end
          prev_key = k;
          have_prev = 1'b1;
          for (int d = 0; d < DIRS; d++) hist[d] = '0;
          bad_vec = 1'b0;
        end
      end
      CMD_READ: begin
        r.kind = KIND_READ;
        r.from_c = it.rrow;
        r.to_c = it.rcol;
        r.cnt = cell_cnt[{it.rrow, it.rcol}];
        r.err = err_sticky;
        expect_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver
  int idle_left;
  item_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(cur);
        n_taken++;
        idle_left = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          in_valid       <= 1'b1;
          in_command     <= cur.cmd;
          in_direction   <= cur.dir;
          in_last_digit  <= cur.last;
          in_entry_index <= cur.idx;
          in_entry_key   <= cur.key;
          in_entry_class <= cur.cls;
          in_read_row    <= cur.rrow;
          in_read_col    <= cur.rcol;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int hold_left, long_left;
  res_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      long_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          $error("unexpected result word kind=%0d count=%0d", out_result_kind, out_cell_count);
          fails++;
        end else begin
          want = expect_q.pop_front();
          if (out_result_kind !== want.kind) begin
            $error("result_kind exp %0d got %0d", want.kind, out_result_kind); fails++;
          end
          if (out_from_class !== want.from_c) begin
            $error("from_class exp %0d got %0d", want.from_c, out_from_class); fails++;
          end
          if (out_to_class !== want.to_c) begin
            $error("to_class exp %0d got %0d", want.to_c, out_to_class); fails++;
          end
          if (out_cell_count !== want.cnt) begin
            $error("cell_count exp %0d got %0d", want.cnt, out_cell_count); fails++;
          end
          if (out_counted !== want.counted) begin
            $error("counted exp %0d got %0d", want.counted, out_counted); fails++;
          end
          if (out_error_seen !== want.err) begin
            $error("error_seen exp %0d got %0d", want.err, out_error_seen); fails++;
          end
        end
        hold_left = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (hold_req > 0) begin
        long_left = hold_req;
        hold_req = 0;
      end
      if (long_left > 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  function automatic item_t noise_item();
    item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  function automatic void push_item(item_t it);
    pend_q.push_back(it);
    n_pushed++;
    n_items++;
  endfunction

  function automatic void push_load(int row, bit [31:0] key, bit [3:0] c);
    item_t it;
    it = noise_item();
    it.cmd = CMD_LOAD;
    it.idx = 6'(row);
    it.key = key;
    it.cls = c;
    gen_key[row] = key;
    push_item(it);
  endfunction

  function automatic void push_read(bit [3:0] r, bit [3:0] c);
    item_t it;
    it = noise_item();
    it.cmd = CMD_READ;
    it.rrow = r;
    it.rcol = c;
    push_item(it);
  endfunction

  // one vector of n copies of a single digit
  function automatic void push_run(bit [3:0] dir, int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it = noise_item();
      it.cmd = CMD_DIGIT;
      it.dir = dir;
      it.last = (i == n - 1);
      push_item(it);
    end
  endfunction

  function automatic bit [31:0] small_key();
    bit [31:0] k;
    int d;
    k = '0;
    repeat ($urandom_range(1, 8)) begin
      d = $urandom_range(0, DIRS-1);
      if (k[4*d +: 4] != 4'hF) k[4*d +: 4]++;
    end
    return k;
  endfunction

  // emit the digits of a histogram in shuffled order, plus some bad digits
  function automatic void push_vector(bit [31:0] key, int nbad);
    bit [3:0] digs[$];
    bit [3:0] t;
    int j;
    item_t it;
    for (int d = 0; d < DIRS; d++)
      repeat (key[4*d +: 4]) digs.push_back(4'(d + 1));
    repeat (nbad)
      digs.push_back($urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(DIRS + 1, 15)));
    if (digs.size() == 0) digs.push_back(4'd0);
    for (int i = digs.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = digs[i]; digs[i] = digs[j]; digs[j] = t;
    end
    foreach (digs[i]) begin
      it = noise_item();
      it.cmd = CMD_DIGIT;
      it.dir = digs[i];
      it.last = (i == digs.size() - 1);
      push_item(it);
    end
  endfunction

  task automatic settle();
    do @(posedge clk); while (n_taken != n_pushed || expect_q.size() != 0);
    repeat (size_now + 12) @(posedge clk);
  endtask

  task automatic write_size(int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_table_size <= 7'(v);
    do @(posedge clk); while (!cfg_ready);
    size_now = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int cnt);
    int p, row;
    item_t it;
    n_items = 0;
    while (n_items < cnt) begin
      p = $urandom_range(0, 99);
      row = $urandom_range(0, TABLE_ROWS - 1);
      if (p < 55 && size_now > 0)
        push_vector(gen_key[$urandom_range(0, size_now - 1)], 0);
      else if (p < 65) push_vector(small_key(), 0);
      else if (p < 73) push_vector(gen_key[row], $urandom_range(1, 2));
      else if (p < 88) push_read(4'($urandom), 4'($urandom));
      else if (p < 96) push_load(row, small_key(), 4'($urandom));
      else begin
        it = noise_item();
        it.cmd = CMD_NONE;
        push_item(it);
      end
      while (pend_q.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // table: duplicate key in row 1 (row 0 must win), empty key, all-ones key
    push_load(0, small_key(), 4'd3);
    push_load(1, gen_key[0], 4'd9);
    for (int r = 2; r < TABLE_ROWS - 2; r++) push_load(r, small_key(), 4'($urandom));
    push_load(TABLE_ROWS - 2, 32'h0, 4'd0);
    push_load(TABLE_ROWS - 1, 32'hFFFF_FFFF, 4'd15);
    settle();
    write_size(TABLE_ROWS);

    push_vector(gen_key[0], 0);
    push_vector(gen_key[1], 0);
    push_vector(32'hFFFF_FFFF, 0);
    push_vector(32'h1111_1111, 0);  // one of each direction
    push_run(4'd1, 17);             // 17 ones saturate the first counter
    push_vector(32'h0, 0);
    push_read(4'd3, 4'd3);
    push_read(4'd15, 4'd15);
    push_read(4'd0, 4'd0);
    begin
      item_t it;
      it = noise_item();
      it.cmd = CMD_NONE;
      push_item(it);
    end
    push_vector(gen_key[2], 1);
    push_vector(gen_key[0], 0);
    settle();
    write_size(0);
    push_vector(gen_key[0], 0);
    push_read(4'd15, 4'd15);
    settle();

    write_size(TABLE_ROWS);
    random_phase(250);
    settle();
    write_size($urandom_range(2, TABLE_ROWS - 1));
    no_gaps = 1'b1;
    random_phase(200);
    settle();
    no_gaps = 1'b0;
    write_size(1);
    random_phase(150);
    settle();
    write_size($urandom_range(1, TABLE_ROWS - 1));
    hold_req = 400;  // hold the output long enough to back up the input
    random_phase(250);
    settle();
    write_size(TABLE_ROWS);
    random_phase(250);
    settle();

    repeat (100) @(posedge clk);
    if (fails == 0 && expect_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
